// ----- hw/rtl/lwd_pkg.sv -----
// Shared types and constants for the LCD window draw command generator.
package lwd_pkg;

    localparam logic [1:0] OP_PIXEL = 2'd0;
    localparam logic [1:0] OP_HLINE = 2'd1;
    localparam logic [1:0] OP_VLINE = 2'd2;

    localparam logic [2:0] CFG_ROTATION     = 3'd0;
    localparam logic [2:0] CFG_PANEL_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_PANEL_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_COLUMN_CMD   = 3'd3;
    localparam logic [2:0] CFG_PAGE_CMD     = 3'd4;
    localparam logic [2:0] CFG_WRITE_CMD    = 3'd5;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // Word slots of one request, in bus order
    localparam logic [3:0] SLOT_COL_CMD = 4'd0;
    localparam logic [3:0] SLOT_C0_HI   = 4'd1;
    localparam logic [3:0] SLOT_C0_LO   = 4'd2;
    localparam logic [3:0] SLOT_C1_HI   = 4'd3;
    localparam logic [3:0] SLOT_C1_LO   = 4'd4;
    localparam logic [3:0] SLOT_PAGE_CMD = 4'd5;
    localparam logic [3:0] SLOT_P0_HI   = 4'd6;
    localparam logic [3:0] SLOT_P0_LO   = 4'd7;
    localparam logic [3:0] SLOT_P1_HI   = 4'd8;
    localparam logic [3:0] SLOT_P1_LO   = 4'd9;
    localparam logic [3:0] SLOT_WR_CMD  = 4'd10;
    localparam logic [3:0] SLOT_COLOR   = 4'd11;

    localparam logic [15:0] BYTE_MASK = 16'h00FF;

    localparam logic [1:0]  ROTATION_RESET     = ROT_0;
    localparam logic [11:0] PANEL_WIDTH_RESET  = 12'd800;
    localparam logic [11:0] PANEL_HEIGHT_RESET = 12'd480;
    localparam logic [15:0] COLUMN_CMD_RESET   = 16'd42;
    localparam logic [15:0] PAGE_CMD_RESET     = 16'd43;
    localparam logic [15:0] WRITE_CMD_RESET    = 16'd44;

    typedef struct packed {
        logic [1:0]  rotation;
        logic [11:0] panel_width;
        logic [11:0] panel_height;
        logic [15:0] column_command;
        logic [15:0] page_command;
        logic [15:0] write_command;
    } cfg_t;

    // Clipped window in panel coordinates
    typedef struct packed {
        logic [11:0] x0;
        logic [11:0] x1;
        logic [11:0] y0;
        logic [11:0] y1;
        logic [11:0] count;
        logic [15:0] color;
    } span_t;

    // Rotated window in controller coordinates
    typedef struct packed {
        logic [11:0] c0;
        logic [11:0] c1;
        logic [11:0] p0;
        logic [11:0] p1;
        logic [11:0] count;
        logic [15:0] color;
    } win_t;

endpackage

// ----- hw/rtl/lwd_front.sv -----
// Front end: clips each request to the panel, drops empty ones, applies rotation.
module lwd_front
    import lwd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [15:0] x,
    input  logic [15:0] y,
    input  logic [15:0] length,
    input  logic [15:0] color,
    output logic        q_valid,
    input  logic        q_ready,
    output win_t        q_data
);

    logic        stage_valid_reg;
    logic        stage_valid_next;
    span_t       stage_reg;
    span_t       span;
    logic        keep;

    logic signed [17:0] xs, ys, ls, wv, hv;
    logic signed [17:0] sa, sb, lim_a, lim_b;
    logic signed [17:0] len2, a2, endp, cnt, aend;
    logic               line_keep, pixel_keep;

    always_comb
    begin
        xs = {{2{x[15]}}, x};
        ys = {{2{y[15]}}, y};
        ls = {{2{length[15]}}, length};
        wv = {6'd0, cfg.panel_width};
        hv = {6'd0, cfg.panel_height};

        // Generic line clip along axis a, fixed position on axis b
        if (operation == OP_HLINE)
        begin
            sa = xs; sb = ys; lim_a = wv; lim_b = hv;
        end
        else
        begin
            sa = ys; sb = xs; lim_a = hv; lim_b = wv;
        end

        len2 = (sa < 0) ? (ls + sa) : ls;
        a2   = (sa < 0) ? 18'sd0 : sa;
        endp = a2 + len2;
        cnt  = (endp >= lim_a) ? (lim_a - a2) : len2;
        aend = a2 + cnt - 18'sd1;

        line_keep  = (sb >= 0) && (sb < lim_b) && (ls > 0) && (len2 > 0) && (a2 < lim_a);
        pixel_keep = (xs >= 0) && (xs < wv) && (ys >= 0) && (ys < hv);

        span.color = color;
        span.x0    = x[11:0];
        span.x1    = x[11:0];
        span.y0    = y[11:0];
        span.y1    = y[11:0];
        span.count = 12'd1;
        keep       = 1'b0;
        case (operation)
            OP_PIXEL:
            begin
                keep = pixel_keep;
            end
            OP_HLINE:
            begin
                keep       = line_keep;
                span.x0    = a2[11:0];
                span.x1    = aend[11:0];
                span.count = cnt[11:0];
            end
            OP_VLINE:
            begin
                keep       = line_keep;
                span.y0    = a2[11:0];
                span.y1    = aend[11:0];
                span.count = cnt[11:0];
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_ready = !stage_valid_reg || q_ready;

    always_comb
    begin
        if (in_valid && in_ready)
            stage_valid_next = keep;
        else
            stage_valid_next = stage_valid_reg && !q_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && keep)
            stage_reg <= span;
    end

    // Rotation; all results stay inside the panel so 12-bit wrap is safe
    logic [11:0] wm1, hm1;

    always_comb
    begin
        wm1          = cfg.panel_width - 12'd1;
        hm1          = cfg.panel_height - 12'd1;
        q_data.count = stage_reg.count;
        q_data.color = stage_reg.color;
        case (cfg.rotation)
            ROT_90:
            begin
                q_data.c0 = stage_reg.y0;
                q_data.c1 = stage_reg.y1;
                q_data.p0 = wm1 - stage_reg.x1;
                q_data.p1 = wm1 - stage_reg.x0;
            end
            ROT_180:
            begin
                q_data.c0 = wm1 - stage_reg.x1;
                q_data.c1 = wm1 - stage_reg.x0;
                q_data.p0 = hm1 - stage_reg.y1;
                q_data.p1 = hm1 - stage_reg.y0;
            end
            ROT_270:
            begin
                q_data.c0 = hm1 - stage_reg.y1;
                q_data.c1 = hm1 - stage_reg.y0;
                q_data.p0 = stage_reg.x0;
                q_data.p1 = stage_reg.x1;
            end
            default:
            begin
                q_data.c0 = stage_reg.x0;
                q_data.c1 = stage_reg.x1;
                q_data.p0 = stage_reg.y0;
                q_data.p1 = stage_reg.y1;
            end
        endcase
    end

    assign q_valid = stage_valid_reg;

endmodule

// ----- hw/rtl/lwd_queue.sv -----
// Small register FIFO of clipped windows between front and back ends.
module lwd_queue
    import lwd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  win_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output win_t pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    win_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- hw/rtl/lwd_back.sv -----
// Back end: walks the twelve bus words of each window into the output register.
module lwd_back
    import lwd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_valid,
    output logic        q_ready,
    input  win_t        q_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_word,
    output logic        out_is_command,
    output logic [11:0] out_repeat,
    output logic        out_last
);

    win_t        cur_reg;
    logic        busy_reg;
    logic [3:0]  slot_reg;
    logic        out_valid_reg;
    logic [15:0] word_reg;
    logic        cmd_reg;
    logic [11:0] rep_reg;
    logic        last_reg;

    logic        out_load;
    logic        last_slot;
    logic [15:0] word_next;
    logic        cmd_next;
    logic [11:0] rep_next;
    logic        last_next;

    function automatic logic [15:0] hi_byte(input logic [11:0] v);
        return ({4'd0, v} >> 8) & BYTE_MASK;
    endfunction

    function automatic logic [15:0] lo_byte(input logic [11:0] v);
        return {4'd0, v} & BYTE_MASK;
    endfunction

    assign out_load  = !out_valid_reg || out_ready;
    assign last_slot = busy_reg && (slot_reg == SLOT_COLOR);
    // Next window is taken as the colour word leaves, so requests run back to back
    assign q_ready   = !busy_reg || (out_load && last_slot);

    always_comb
    begin
        cmd_next  = 1'b0;
        rep_next  = 12'd1;
        last_next = 1'b0;
        case (slot_reg)
            SLOT_COL_CMD:
            begin
                word_next = cfg.column_command;
                cmd_next  = 1'b1;
            end
            SLOT_C0_HI:    word_next = hi_byte(cur_reg.c0);
            SLOT_C0_LO:    word_next = lo_byte(cur_reg.c0);
            SLOT_C1_HI:    word_next = hi_byte(cur_reg.c1);
            SLOT_C1_LO:    word_next = lo_byte(cur_reg.c1);
            SLOT_PAGE_CMD:
            begin
                word_next = cfg.page_command;
                cmd_next  = 1'b1;
            end
            SLOT_P0_HI:    word_next = hi_byte(cur_reg.p0);
            SLOT_P0_LO:    word_next = lo_byte(cur_reg.p0);
            SLOT_P1_HI:    word_next = hi_byte(cur_reg.p1);
            SLOT_P1_LO:    word_next = lo_byte(cur_reg.p1);
            SLOT_WR_CMD:
            begin
                word_next = cfg.write_command;
                cmd_next  = 1'b1;
            end
            SLOT_COLOR:
            begin
                word_next = cur_reg.color;
                rep_next  = cur_reg.count;
                last_next = 1'b1;
            end
            default:       word_next = cur_reg.color;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            slot_reg      <= SLOT_COL_CMD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_valid && q_ready)
            begin
                busy_reg <= 1'b1;
                slot_reg <= SLOT_COL_CMD;
            end
            else if (out_load && last_slot)
            begin
                busy_reg <= 1'b0;
            end
            else if (out_load && busy_reg)
            begin
                slot_reg <= slot_reg + 4'd1;
            end
            if (out_load)
                out_valid_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
            cur_reg <= q_data;
        if (out_load && busy_reg)
        begin
            word_reg <= word_next;
            cmd_reg  <= cmd_next;
            rep_reg  <= rep_next;
            last_reg <= last_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_word       = word_reg;
    assign out_is_command = cmd_reg;
    assign out_repeat     = rep_reg;
    assign out_last       = last_reg;

endmodule

// ----- hw/rtl/lcd_window_draw_command_generator.sv -----
// Top level of the LCD window draw command generator: config registers and stream ports.
// Each accepted draw request (pixel, horizontal or vertical line) is clipped to the
// panel; a request that leaves nothing on the panel, or has an unused operation code,
// produces no beats. A surviving request produces exactly twelve output beats: column
// command, four column bytes, page command, four page bytes, write command, and the
// colour word carrying its repeat count (tlast). The word sequencer emits one beat per
// cycle while the receiver accepts, so surviving requests run back to back; the input
// side accepts one request per cycle while the window queue (QUEUE_DEPTH entries plus
// one clip stage) has room. Output words are registered before they leave.
// Configuration writes must only be issued while the block is idle.
module lcd_window_draw_command_generator
    import lwd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wen,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // x[15:0], y[31:16], length[47:32], color[63:48]
    input  logic [1:0]  s_tuser,   // operation[1:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // word[15:0], repeat_res[27:16], zero[31:28]
    output logic        m_tuser,   // is_command[0]
    output logic        m_tlast
);

    cfg_t cfg_reg;
    win_t q_in_data, q_out_data;
    logic q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    logic [15:0] out_word;
    logic [11:0] out_repeat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rotation       <= ROTATION_RESET;
            cfg_reg.panel_width    <= PANEL_WIDTH_RESET;
            cfg_reg.panel_height   <= PANEL_HEIGHT_RESET;
            cfg_reg.column_command <= COLUMN_CMD_RESET;
            cfg_reg.page_command   <= PAGE_CMD_RESET;
            cfg_reg.write_command  <= WRITE_CMD_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_ROTATION:     cfg_reg.rotation       <= cfg_wdata[1:0];
                CFG_PANEL_WIDTH:  cfg_reg.panel_width    <= cfg_wdata[11:0];
                CFG_PANEL_HEIGHT: cfg_reg.panel_height   <= cfg_wdata[11:0];
                CFG_COLUMN_CMD:   cfg_reg.column_command <= cfg_wdata;
                CFG_PAGE_CMD:     cfg_reg.page_command   <= cfg_wdata;
                CFG_WRITE_CMD:    cfg_reg.write_command  <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    lwd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .operation (s_tuser),
        .x         (s_tdata[15:0]),
        .y         (s_tdata[31:16]),
        .length    (s_tdata[47:32]),
        .color     (s_tdata[63:48]),
        .q_valid   (q_in_valid),
        .q_ready   (q_in_ready),
        .q_data    (q_in_data)
    );

    lwd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_in_valid),
        .push_ready (q_in_ready),
        .push_data  (q_in_data),
        .pop_valid  (q_out_valid),
        .pop_ready  (q_out_ready),
        .pop_data   (q_out_data)
    );

    lwd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_valid        (q_out_valid),
        .q_ready        (q_out_ready),
        .q_data         (q_out_data),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_word       (out_word),
        .out_is_command (m_tuser),
        .out_repeat     (out_repeat),
        .out_last       (m_tlast)
    );

    assign m_tdata = {4'd0, out_repeat, out_word};

    // Colour word is always data and carries a nonzero pixel count
    a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> !m_tuser && (m_tdata[27:16] != 12'd0))
        else $error("colour beat malformed");

    // Every beat before the colour word is sent exactly once
    a_repeat_one: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[27:16] == 12'd1)
        else $error("repeat count above one on a non-colour beat");

    // A command beat is never followed directly by another command beat
    a_cmd_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser |=> !(m_tvalid && m_tuser))
        else $error("two command beats in a row");

    // A window is taken from the queue only between requests on the output stream
    a_queue_flow: assert property (@(posedge clk) disable iff (!rst_n)
        q_out_valid && q_out_ready |=> !m_tvalid || m_tlast || m_tuser
            || $past(m_tvalid && !m_tready))
        else $error("window taken while output stream mid-request");

endmodule

// ----- tb/lwd_checker.sv -----
// Checker for the LCD window draw command generator: tracks config, predicts bus words, compares.
`timescale 1ns / 100ps

module lwd_checker
    import lwd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wen,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // x[15:0], y[31:16], length[47:32], color[63:48]
    input  logic [1:0]  s_tuser,   // operation[1:0]

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // word[15:0], repeat_res[27:16], zero[31:28]
    input  logic        m_tuser,   // is_command[0]
    input  logic        m_tlast,

    output int          mismatches,
    output int          words_pending,
    output int          words_checked,
    output int          requests_drawn
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [15:0] word;
        logic        is_command;
        logic [11:0] repeat_count;
        logic        last_word;
    } bus_word_t;

    bus_word_t expected_words[$];
    cfg_t      panel;

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: %s", $time, msg);
    endtask

    function automatic void push_word(input logic [15:0] word, input logic is_cmd,
                                      input logic [11:0] rep, input logic lst);
        bus_word_t bw;
        bw.word         = word;
        bw.is_command   = is_cmd;
        bw.repeat_count = rep;
        bw.last_word    = lst;
        expected_words.push_back(bw);
    endfunction

    // Coordinate goes out as high byte, then low byte
    function automatic void push_coord(input int v);
        logic [15:0] cv;
        cv = 16'(v);
        push_word((cv >> 8) & BYTE_MASK, 1'b0, 12'd1, 1'b0);
        push_word(cv & BYTE_MASK, 1'b0, 12'd1, 1'b0);
    endfunction

    // Clip one draw request to the panel, rotate the window, queue its twelve bus words
    function automatic void queue_draw_words(input logic [1:0] op,
                                             input logic signed [15:0] x_in,
                                             input logic signed [15:0] y_in,
                                             input logic signed [15:0] len_in,
                                             input logic [15:0] color);
        int x, y, len, w, h;
        int x0, x1, y0, y1, count;
        int c0, c1, p0, p1;
        x   = x_in;
        y   = y_in;
        len = len_in;
        w   = panel.panel_width;
        h   = panel.panel_height;
        case (op)
            OP_PIXEL:
            begin
                if (x < 0 || x >= w || y < 0 || y >= h)
                    return;
                count = 1;
                x0 = x; x1 = x;
                y0 = y; y1 = y;
            end
            OP_HLINE:
            begin
                if (y < 0 || y >= h || len <= 0)
                    return;
                if (x < 0)
                begin
                    len += x;
                    x = 0;
                    if (len <= 0)
                        return;
                end
                if (x >= w)
                    return;
                if (x + len >= w)
                    len = w - x;
                count = len;
                x0 = x; x1 = x + len - 1;
                y0 = y; y1 = y;
            end
            OP_VLINE:
            begin
                if (x < 0 || x >= w || len <= 0)
                    return;
                if (y < 0)
                begin
                    len += y;
                    y = 0;
                    if (len <= 0)
                        return;
                end
                if (y >= h)
                    return;
                if (y + len >= h)
                    len = h - y;
                count = len;
                x0 = x; x1 = x;
                y0 = y; y1 = y + len - 1;
            end
            default:
                return;
        endcase

        case (panel.rotation)
            ROT_90:
            begin
                c0 = y0;         c1 = y1;
                p0 = w - 1 - x1; p1 = w - 1 - x0;
            end
            ROT_180:
            begin
                c0 = w - 1 - x1; c1 = w - 1 - x0;
                p0 = h - 1 - y1; p1 = h - 1 - y0;
            end
            ROT_270:
            begin
                c0 = h - 1 - y1; c1 = h - 1 - y0;
                p0 = x0;         p1 = x1;
            end
            default:
            begin
                c0 = x0; c1 = x1;
                p0 = y0; p1 = y1;
            end
        endcase

        push_word(panel.column_command, 1'b1, 12'd1, 1'b0);
        push_coord(c0);
        push_coord(c1);
        push_word(panel.page_command, 1'b1, 12'd1, 1'b0);
        push_coord(p0);
        push_coord(p1);
        push_word(panel.write_command, 1'b1, 12'd1, 1'b0);
        push_word(color, 1'b0, 12'(count), 1'b1);
        requests_drawn++;
    endfunction

    task automatic check_word(input logic [15:0] word, input logic is_cmd,
                              input logic [11:0] rep, input logic lst);
        bus_word_t want;
        words_checked++;
        if (expected_words.size() == 0)
        begin
            note_mismatch($sformatf("unexpected beat word=%h cmd=%b rep=%0d last=%b",
                                    word, is_cmd, rep, lst));
            return;
        end
        want = expected_words.pop_front();
        if (word !== want.word || is_cmd !== want.is_command ||
            rep !== want.repeat_count || lst !== want.last_word)
            note_mismatch($sformatf(
                "exp word=%h cmd=%b rep=%0d last=%b, got word=%h cmd=%b rep=%0d last=%b",
                want.word, want.is_command, want.repeat_count, want.last_word,
                word, is_cmd, rep, lst));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel.rotation       = ROTATION_RESET;
            panel.panel_width    = PANEL_WIDTH_RESET;
            panel.panel_height   = PANEL_HEIGHT_RESET;
            panel.column_command = COLUMN_CMD_RESET;
            panel.page_command   = PAGE_CMD_RESET;
            panel.write_command  = WRITE_CMD_RESET;
            expected_words.delete();
            mismatches     = 0;
            words_checked  = 0;
            requests_drawn = 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    CFG_ROTATION:     panel.rotation       = cfg_wdata[1:0];
                    CFG_PANEL_WIDTH:  panel.panel_width    = cfg_wdata[11:0];
                    CFG_PANEL_HEIGHT: panel.panel_height   = cfg_wdata[11:0];
                    CFG_COLUMN_CMD:   panel.column_command = cfg_wdata;
                    CFG_PAGE_CMD:     panel.page_command   = cfg_wdata;
                    CFG_WRITE_CMD:    panel.write_command  = cfg_wdata;
                    default: ;
                endcase
            end
            // output first: a word can never stem from a request accepted at the same edge
            if (m_tvalid && m_tready)
                check_word(m_tdata[15:0], m_tuser, m_tdata[27:16], m_tlast);
            if (s_tvalid && s_tready)
                queue_draw_words(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[47:32],
                                 s_tdata[63:48]);
        end
        words_pending = expected_words.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top: clock, reset, draw request and config stimulus, receiver stalls, verdict.
`timescale 1ns / 100ps

module tb_top;
    import lwd_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int SETTLE_CYCLES  = 32;
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_GAP        = 40;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 9;
    localparam int HOLD_ITEMS     = 12;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [2:0] CFG_SPARE_6 = 3'd6;
    localparam logic [2:0] CFG_SPARE_7 = 3'd7;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_wen   = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int mismatches;
    int words_pending;
    int words_checked;
    int requests_drawn;

    int requests_sent = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int cur_w         = PANEL_WIDTH_RESET;
    int cur_h         = PANEL_HEIGHT_RESET;
    int timeout_count;

    // long receiver hold-off: main flips hold_toggle, receiver process owns the count
    logic hold_toggle = 1'b0;
    logic hold_seen   = 1'b0;
    int   hold_left   = 0;

    logic [1:0]  phase_rot  [NUM_PHASES] = '{ROT_90, ROT_180, ROT_270, ROT_0,
                                             ROT_90, ROT_180, ROT_270, ROT_0};
    logic [11:0] phase_w    [NUM_PHASES] = '{12'd4095, 12'd1, 12'd320, 12'd16,
                                             12'd7, 12'd4095, 12'd1, 12'd800};
    logic [11:0] phase_h    [NUM_PHASES] = '{12'd4095, 12'd1, 12'd240, 12'd4095,
                                             12'd3, 12'd37, 12'd4095, 12'd480};
    logic [15:0] phase_ccmd [NUM_PHASES] = '{16'h0000, 16'hFFFF, 16'h002A, 16'h1234,
                                             16'h8000, 16'h00FF, 16'h7FFF, 16'h002A};
    logic [15:0] phase_pcmd [NUM_PHASES] = '{16'hFFFF, 16'h0000, 16'h002B, 16'hABCD,
                                             16'h0001, 16'hFF00, 16'h5555, 16'h002B};
    logic [15:0] phase_wcmd [NUM_PHASES] = '{16'h002C, 16'h5A5A, 16'h002C, 16'h8001,
                                             16'hAAAA, 16'h0F0F, 16'hFFFE, 16'h002C};

    always #(CLK_HALF) clk = ~clk;

    lcd_window_draw_command_generator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    lwd_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wen        (cfg_wen),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatches     (mismatches),
        .words_pending  (words_pending),
        .words_checked  (words_checked),
        .requests_drawn (requests_drawn)
    );

    always @(negedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Mode changes land just after a rising edge so the receiver reads them cleanly
    task automatic set_mode(input int idle, input int stall);
        @(posedge clk);
        send_idle_pct = idle;
        stall_pct     = stall;
    endtask

    task automatic send_request(input logic [1:0] op, input int x, input int y,
                                input int len, input int color);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {16'(color), 16'(len), 16'(y), 16'(x)};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        requests_sent++;
    endtask

    // Mostly on-panel requests with random content, some raw noise and unused opcodes
    task automatic send_random_request(input bit allow_noise);
        int          pick, x, y, len, mx, my;
        logic [1:0]  op;
        pick = allow_noise ? $urandom_range(99) : 99;
        op   = 2'($urandom_range(2));
        mx   = cur_w / 8 + 2;
        my   = cur_h / 8 + 2;
        if (pick < 8)
        begin
            op  = OP_UNUSED;
            x   = $urandom_range(16'hFFFF);
            y   = $urandom_range(16'hFFFF);
            len = $urandom_range(16'hFFFF);
        end
        else if (pick < 25)
        begin
            x   = $urandom_range(16'hFFFF);
            y   = $urandom_range(16'hFFFF);
            len = $urandom_range(16'hFFFF);
        end
        else
        begin
            x   = int'($urandom_range(cur_w + 2 * mx)) - mx;
            y   = int'($urandom_range(cur_h + 2 * my)) - my;
            len = int'($urandom_range((op == OP_VLINE ? cur_h : cur_w) + 8)) - 4;
        end
        send_request(op, x, y, len, $urandom_range(16'hFFFF));
    endtask

    // Stop offering, wait for every expected word, then let dropped requests flush
    task automatic drain_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (words_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wen   <= 1'b0;
    endtask

    task automatic set_panel(input logic [1:0] rot, input logic [11:0] w, input logic [11:0] h,
                             input logic [15:0] ccmd, input logic [15:0] pcmd,
                             input logic [15:0] wcmd);
        drain_idle();
        write_reg(CFG_ROTATION, 16'(rot));
        write_reg(CFG_PANEL_WIDTH, 16'(w));
        write_reg(CFG_PANEL_HEIGHT, 16'(h));
        write_reg(CFG_COLUMN_CMD, ccmd);
        write_reg(CFG_PAGE_CMD, pcmd);
        write_reg(CFG_WRITE_CMD, wcmd);
        cur_w = w;
        cur_h = h;
    endtask

    initial
    begin : watchdog
        for (timeout_count = 0; timeout_count < TIMEOUT_CYCLES; timeout_count++)
            @(posedge clk);
        $display("timeout after %0d cycles, %0d words still expected",
                 TIMEOUT_CYCLES, words_pending);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        set_mode(0, 0);

        // directed: reset config, 800x480, no rotation
        send_request(OP_PIXEL, 0, 0, -32768, 16'h0000);
        send_request(OP_PIXEL, 799, 479, 32767, 16'hFFFF);
        send_request(OP_PIXEL, -1, 5, 1, $urandom_range(16'hFFFF));
        send_request(OP_PIXEL, 800, 5, 1, $urandom_range(16'hFFFF));
        send_request(OP_PIXEL, 5, 480, 1, $urandom_range(16'hFFFF));
        send_request(OP_PIXEL, -32768, -32768, 0, $urandom_range(16'hFFFF));
        send_request(OP_PIXEL, 32767, 32767, 0, $urandom_range(16'hFFFF));
        send_request(OP_HLINE, 10, 10, 0, $urandom_range(16'hFFFF));
        send_request(OP_HLINE, 10, 10, -32768, $urandom_range(16'hFFFF));
        send_request(OP_HLINE, 0, 0, 32767, $urandom_range(16'hFFFF));
        send_request(OP_HLINE, -10, 3, 5, $urandom_range(16'hFFFF));
        send_request(OP_HLINE, -10, 3, 20, $urandom_range(16'hFFFF));
        send_request(OP_HLINE, 795, 3, 100, $urandom_range(16'hFFFF));
        send_request(OP_HLINE, 800, 3, 1, $urandom_range(16'hFFFF));
        send_request(OP_HLINE, 0, 480, 5, $urandom_range(16'hFFFF));
        send_request(OP_HLINE, -32768, 1, 32767, $urandom_range(16'hFFFF));
        send_request(OP_VLINE, 5, 0, 32767, $urandom_range(16'hFFFF));
        send_request(OP_VLINE, 5, -3, 10, $urandom_range(16'hFFFF));
        send_request(OP_VLINE, 5, 470, 20, $urandom_range(16'hFFFF));
        send_request(OP_VLINE, 800, 0, 5, $urandom_range(16'hFFFF));
        send_request(OP_VLINE, 5, -5, 5, $urandom_range(16'hFFFF));
        send_request(OP_VLINE, 5, 480, 1, $urandom_range(16'hFFFF));
        send_request(OP_UNUSED, 1, 1, 5, 16'h1234);

        // backpressure: receiver holds off while requests keep coming
        hold_toggle = ~hold_toggle;
        repeat (HOLD_ITEMS) send_random_request(1'b0);
        drain_idle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_panel(phase_rot[p], phase_w[p], phase_h[p],
                      phase_ccmd[p], phase_pcmd[p], phase_wcmd[p]);
            if (p == NUM_PHASES - 1)
            begin
                // spare indexes must leave the registers alone
                write_reg(CFG_SPARE_6, 16'hFFFF);
                write_reg(CFG_SPARE_7, 16'h0001);
            end
            case (p % 4)
                0: set_mode(0, 0);
                1: set_mode(79, 0);
                2: set_mode(0, 79);
                default: set_mode(25, 25);
            endcase
            if (p == 0)
            begin
                // full-width line and far-edge column on the largest panel
                send_request(OP_HLINE, 0, 4094, 32767, $urandom_range(16'hFFFF));
                send_request(OP_VLINE, 4094, 0, 32767, $urandom_range(16'hFFFF));
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 3 && i == PHASE_ITEMS / 2)
                    drain_idle();
                send_random_request(1'b1);
            end
        end

        // zero-width panel drops every request
        set_panel(ROT_0, 12'd0, 12'd300, COLUMN_CMD_RESET, PAGE_CMD_RESET, WRITE_CMD_RESET);
        set_mode(0, 0);
        send_request(OP_PIXEL, 0, 0, 1, $urandom_range(16'hFFFF));
        send_request(OP_HLINE, 0, 0, 10, $urandom_range(16'hFFFF));
        send_request(OP_VLINE, 0, 0, 10, $urandom_range(16'hFFFF));

        drain_idle();
        $display("Summary: %0d draw requests sent, %0d drawn, %0d bus words checked",
                 requests_sent, requests_drawn, words_checked);
        $display("Covered all rotations, panels 1x1 to 4095x4095, a zero-width panel, %s",
                 "clipping edges and stalls on both sides");
        if (mismatches == 0 && words_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/lwd_pkg.sv
hw/rtl/lwd_front.sv
hw/rtl/lwd_queue.sv
hw/rtl/lwd_back.sv
hw/rtl/lcd_window_draw_command_generator.sv
tb/lwd_checker.sv
tb/tb_top.sv
